/* sv/gmd_pkg.sv */
// Shared types, constants and constant functions for the Gray M-PSK demapper.
// Holds the quarter-wave sine ROM (Q2.14) and the per-point constant lookup.
// No dependencies.
package gmd_pkg;

    localparam int MAX_BITS_DEF    = 6;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int COEF_W = 16;   // Q2.14 cos/sin, signed
    localparam int NORM_W = 32;   // squared magnitude of a point, unsigned

    // configuration port
    localparam int          BPS_W     = 3;
    localparam int          ADDR_W    = 3;
    localparam logic [BPS_W-1:0] BPS_RESET = 3'd2;
    localparam logic [0:0]  REG_BPS   = 1'b0;

    typedef struct packed {
        logic signed [COEF_W-1:0] cos_v;
        logic signed [COEF_W-1:0] sin_v;
        logic [NORM_W-1:0]        norm;
    } t_point;

    // round(16384 * sin(d degrees)), d = 0..90
    localparam int QUARTER_SINE [91] = '{
            0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
         2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
         5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
         8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    // sine of a whole-degree angle in 0..359
    function automatic int wave_sin(int d);
        int r;
        if (d <= 90) begin
            r = QUARTER_SINE[d];
        end else if (d <= 180) begin
            r = QUARTER_SINE[180 - d];
        end else if (d <= 270) begin
            r = -QUARTER_SINE[d - 180];
        end else begin
            r = -QUARTER_SINE[360 - d];
        end
        return r;
    endfunction

    // point i of a 2^n constellation; zero for points outside it
    function automatic t_point point_at(int i, int n);
        t_point p;
        int     deg;
        int     cdeg;
        int     c;
        int     s;
        p = '0;
        if (i < (1 << n)) begin
            deg  = (360 * i) >> n;
            s    = wave_sin(deg);
            cdeg = deg + 90;
            if (cdeg >= 360) begin
                cdeg = cdeg - 360;
            end
            c       = wave_sin(cdeg);
            p.cos_v = COEF_W'(c);
            p.sin_v = COEF_W'(s);
            p.norm  = NORM_W'(c * c + s * s);
        end
        return p;
    endfunction

endpackage

/* sv/gmd_lane.sv */
// One distance lane of the demapper: correlates the sample with one point.
// Two register stages: products, then metric norm - 8*(x*c + y*s).
// Depends on gmd_pkg.
module gmd_lane #(
    parameter int LANE         = 0,
    parameter int MAX_BITS     = gmd_pkg::MAX_BITS_DEF,
    parameter int SAMPLE_WIDTH = gmd_pkg::SAMPLE_WIDTH_DEF,
    parameter int NB           = $clog2(MAX_BITS + 1),
    parameter int PW           = SAMPLE_WIDTH + gmd_pkg::COEF_W,
    parameter int MW           = ((PW + 4 > gmd_pkg::NORM_W) ? PW + 4 : gmd_pkg::NORM_W) + 1
) (
    input  logic                           i_clk,
    input  logic [NB-1:0]                  i_n_eff,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y,
    output logic signed [MW-1:0]           o_metric,
    output logic                           o_ok
);

    localparam int SELW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

    gmd_pkg::t_point pt_tab [MAX_BITS];
    gmd_pkg::t_point pt;
    logic [SELW-1:0] sel;
    logic            lane_in;

    logic signed [PW-1:0]             r_pc;
    logic signed [PW-1:0]             r_ps;
    logic [gmd_pkg::NORM_W-1:0]       r_norm;
    logic                             r_ok1;
    logic signed [PW:0]               dot;
    logic signed [MW-1:0]             n_metric;
    logic signed [MW-1:0]             r_metric;
    logic                             r_ok2;

    for (genvar g = 0; g < MAX_BITS; g++) begin : g_tab
        assign pt_tab[g] = gmd_pkg::point_at(LANE, g + 1);
    end

    assign sel     = SELW'(i_n_eff - NB'(1));
    assign pt      = pt_tab[sel];
    assign lane_in = (32'(LANE) >> i_n_eff) == 32'd0;

    always_ff @(posedge i_clk) begin
        r_pc   <= PW'(i_x) * PW'(pt.cos_v);
        r_ps   <= PW'(i_y) * PW'(pt.sin_v);
        r_norm <= pt.norm;
        r_ok1  <= lane_in;
    end

    // |x|^2 is common to all lanes and dropped
    always_comb begin
        dot      = (PW + 1)'(r_pc) + (PW + 1)'(r_ps);
        n_metric = MW'({1'b0, r_norm}) - (MW'(dot) <<< 3);
    end

    always_ff @(posedge i_clk) begin
        r_metric <= n_metric;
        r_ok2    <= r_ok1;
    end

    assign o_metric = r_metric;
    assign o_ok     = r_ok2;

endmodule

/* sv/gmd_min_tree.sv */
// Registered binary minimum tree over the lane metrics, one level per stage.
// Lower index wins ties; lanes outside the constellation never win.
// Depends on nothing but its parameters.
module gmd_min_tree #(
    parameter int LEVELS = 6,
    parameter int MW     = 37
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [MW-1:0] i_metric [2**LEVELS],
    input  logic                 i_ok [2**LEVELS],
    output logic                 o_valid,
    output logic [LEVELS-1:0]    o_index
);

    localparam int LEAVES = 2 ** LEVELS;

    // heap order: node k combines 2k and 2k+1; leaves are 2^L..2^(L+1)-1
    logic signed [MW-1:0]     r_m   [1:LEAVES-1];
    logic [LEVELS-1:0]        r_idx [1:LEAVES-1];
    logic                     r_ok  [1:LEAVES-1];
    logic [LEVELS-1:0]        r_vld;

    for (genvar k = 1; k < LEAVES; k++) begin : g_node
        logic signed [MW-1:0] lm;
        logic signed [MW-1:0] rm;
        logic [LEVELS-1:0]    li;
        logic [LEVELS-1:0]    ri;
        logic                 lok;
        logic                 rok;
        logic                 take_l;

        if (2 * k >= LEAVES) begin : g_leaf
            assign lm  = i_metric[2 * k - LEAVES];
            assign rm  = i_metric[2 * k + 1 - LEAVES];
            assign lok = i_ok[2 * k - LEAVES];
            assign rok = i_ok[2 * k + 1 - LEAVES];
            assign li  = LEVELS'(2 * k - LEAVES);
            assign ri  = LEVELS'(2 * k + 1 - LEAVES);
        end else begin : g_inner
            assign lm  = r_m[2 * k];
            assign rm  = r_m[2 * k + 1];
            assign lok = r_ok[2 * k];
            assign rok = r_ok[2 * k + 1];
            assign li  = r_idx[2 * k];
            assign ri  = r_idx[2 * k + 1];
        end

        assign take_l = lok && (!rok || (lm <= rm));

        always_ff @(posedge i_clk) begin
            r_m[k]   <= take_l ? lm : rm;
            r_idx[k] <= take_l ? li : ri;
            r_ok[k]  <= lok || rok;
        end
    end

    logic [LEVELS-1:0] n_vld;
    if (LEVELS > 1) begin : g_vshift
        assign n_vld = {r_vld[LEVELS-2:0], i_valid};
    end else begin : g_vone
        assign n_vld = i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid = r_vld[LEVELS-1];
    assign o_index = r_idx[1];

endmodule

/* sv/gray_mpsk_min_distance_demapper.sv */
// Top level of the Gray-coded M-PSK minimum-distance demapper.
// Depends on gmd_pkg, gmd_lane and gmd_min_tree.
//
//  channel   signals                                   direction  handshake
//  sample    start, busy, i_i_sample, i_q_sample       in         start & !busy
//  result    o_valid, o_symbol_bits, o_point_index     out        one-cycle strobe
//  config    psel, penable, pwrite, paddr, pwdata,     in/out     APB, pready tied high
//            prdata, pready
//
// One item is taken every cycle; busy is never raised.
// The pipeline is the input register, the product and metric stages of the
// 2^MAX_BITS_PER_SYMBOL lanes, one minimum-tree level per bit, then the output
// register; the tree depth thus follows MAX_BITS_PER_SYMBOL.
// Synchronous active-low reset clears the valid pipeline and sets QPSK.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module gray_mpsk_min_distance_demapper #(
    parameter int MAX_BITS_PER_SYMBOL = gmd_pkg::MAX_BITS_DEF,
    parameter int SAMPLE_WIDTH        = gmd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_i_sample,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_q_sample,
    output logic                             o_valid,
    output logic [MAX_BITS_PER_SYMBOL-1:0]   o_symbol_bits,
    output logic [MAX_BITS_PER_SYMBOL-1:0]   o_point_index,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gmd_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int L      = MAX_BITS_PER_SYMBOL;
    localparam int LANES  = 2 ** L;
    localparam int NB     = $clog2(L + 1);
    localparam int PW     = SAMPLE_WIDTH + gmd_pkg::COEF_W;
    localparam int MW     = ((PW + 4 > gmd_pkg::NORM_W) ? PW + 4 : gmd_pkg::NORM_W) + 1;
    localparam int BW     = gmd_pkg::BPS_W;
    localparam int CW     = (BW > NB) ? BW : NB;

    // configuration register
    logic [BW-1:0] r_bps;
    logic [BW-1:0] n_bps;
    logic          wr_en;
    logic          reg_hit;
    logic [NB-1:0] n_eff;
    logic [CW-1:0] bps_w;

    assign pready  = 1'b1;
    assign reg_hit = paddr[gmd_pkg::ADDR_W-1:2] == gmd_pkg::REG_BPS;
    assign wr_en   = psel && penable && pwrite && pready && reg_hit;
    assign n_bps   = wr_en ? pwdata[BW-1:0] : r_bps;
    assign prdata  = reg_hit ? 32'(r_bps) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps <= gmd_pkg::BPS_RESET;
        end else begin
            r_bps <= n_bps;
        end
    end

    // zero acts as BPSK, anything above the maximum saturates
    assign bps_w = CW'(r_bps);
    always_comb begin
        if (bps_w == CW'(0)) begin
            n_eff = NB'(1);
        end else if (bps_w > CW'(L)) begin
            n_eff = NB'(L);
        end else begin
            n_eff = NB'(bps_w);
        end
    end

    // input register
    logic                           accept;
    logic                           r_vld0;
    logic [1:0]                     r_vld_lane;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SAMPLE_WIDTH-1:0] r_y;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= i_i_sample;
            r_y <= i_q_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0     <= 1'b0;
            r_vld_lane <= '0;
        end else begin
            r_vld0     <= accept;
            r_vld_lane <= {r_vld_lane[0], r_vld0};
        end
    end

    // distance lanes
    logic signed [MW-1:0] metric [LANES];
    logic                 ok     [LANES];

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        gmd_lane #(
            .LANE         (j),
            .MAX_BITS     (L),
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .NB           (NB),
            .PW           (PW),
            .MW           (MW)
        ) u_lane (
            .i_clk    (i_clk),
            .i_n_eff  (n_eff),
            .i_x      (r_x),
            .i_y      (r_y),
            .o_metric (metric[j]),
            .o_ok     (ok[j])
        );
    end

    // nearest point
    logic         tree_vld;
    logic [L-1:0] tree_idx;

    gmd_min_tree #(
        .LEVELS (L),
        .MW     (MW)
    ) u_tree (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld_lane[1]),
        .i_metric (metric),
        .i_ok     (ok),
        .o_valid  (tree_vld),
        .o_index  (tree_idx)
    );

    // output register
    logic         r_out_vld;
    logic [L-1:0] r_idx;
    logic [L-1:0] r_gray;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= tree_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= tree_idx;
        r_gray <= tree_idx ^ (tree_idx >> 1);
    end

    assign o_valid       = r_out_vld;
    assign o_point_index = r_idx;
    assign o_symbol_bits = r_gray;

endmodule
